/* rtl/core/quaternion_to_euler_rpy_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to roll/pitch/yaw converter
// Each check is a clocked implication with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_RPY_ASSERT_SVH
`define QUATERNION_TO_EULER_RPY_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define Q2E_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("q2e assertion failed");
// next-cycle implication
`define Q2E_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("q2e assertion failed");
`else
`define Q2E_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define Q2E_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg
// Widths, constants and the arctangent table of the quaternion converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int ACC_FRAC   = 30;   // angle accumulator fraction bits
  localparam int ACC_W      = 35;   // angle accumulator width, holds +-(pi + 1.75)
  localparam int VEC_W      = 37;   // CORDIC vector width after gain growth
  localparam int TERM_W     = 35;   // sums of Q.28 products
  localparam int PITCH_W    = 30;   // saturated pitch term, +-2^28
  localparam int SQ_W       = 58;   // square root remainder width
  localparam int SQRT_STEPS = 29;   // result bits of the root, <= 2^28
  localparam int ROOT_W     = 29;
  localparam int CORDIC_MAX = 24;

  localparam logic signed [ACC_W-1:0]  PI_Q30   = 35'sd3373259426;
  localparam logic signed [TERM_W-1:0] ONE_Q28  = 35'sd268435456;

  typedef struct packed {
    logic signed [TERM_W-1:0]  t0;
    logic signed [TERM_W-1:0]  t1;
    logic signed [PITCH_W-1:0] t2;
    logic signed [TERM_W-1:0]  t3;
    logic signed [TERM_W-1:0]  t4;
  } terms_t;

  // atan(2^-i) in Q.30
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:    r = 30'd843314857;
      5'd1:    r = 30'd497837829;
      5'd2:    r = 30'd263043837;
      5'd3:    r = 30'd133525159;
      5'd4:    r = 30'd67021687;
      5'd5:    r = 30'd33543516;
      5'd6:    r = 30'd16775851;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194283;
      5'd9:    r = 30'd2097149;
      5'd10:   r = 30'd1048576;
      5'd11:   r = 30'd524288;
      5'd12:   r = 30'd262144;
      5'd13:   r = 30'd131072;
      5'd14:   r = 30'd65536;
      5'd15:   r = 30'd32768;
      5'd16:   r = 30'd16384;
      5'd17:   r = 30'd8192;
      5'd18:   r = 30'd4096;
      5'd19:   r = 30'd2048;
      5'd20:   r = 30'd1024;
      5'd21:   r = 30'd512;
      5'd22:   r = 30'd256;
      5'd23:   r = 30'd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/q2e_cordic.sv */
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC atan2 with rounding and saturation to the field.
// ----------------------------------------------------------------------------
module q2e_cordic import q2e_pkg::*; #(
  parameter int STAGES    = 16,
  parameter int FRAC_BITS = 13,
  parameter int OUT_W     = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [VEC_W-1:0]  y_in,
  input  logic signed [VEC_W-1:0]  x_in,
  output logic signed [OUT_W-1:0]  angle
);

  localparam int SHIFT = ACC_FRAC - FRAC_BITS;
  localparam int V_W   = ACC_W - SHIFT;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (SHIFT - 1);
  localparam logic signed [63:0] HI = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] LO = -HI - 64'sd1;

  logic signed [VEC_W-1:0] xs [STAGES+1];
  logic signed [VEC_W-1:0] ys [STAGES+1];
  logic signed [ACC_W-1:0] zs [STAGES+1];
  logic                    zf [STAGES+1];

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ACC_W-1:0] ANG = ACC_W'(atan_q30(5'(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ANG;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ANG;
        end
      end
    end
  end

  logic signed [ACC_W-1:0] zsel;
  logic signed [ACC_W-1:0] rnd;
  logic signed [V_W-1:0]   v;
  logic signed [63:0]      vw;

  always_comb begin
    zsel = zf[STAGES] ? '0 : zs[STAGES];
    rnd  = zsel + HALF;
    v    = rnd[ACC_W-1:SHIFT];
    vw   = 64'(v);
    if (vw > HI)      angle = OUT_W'(HI);
    else if (vw < LO) angle = OUT_W'(LO);
    else              angle = OUT_W'(vw);
  end

endmodule

/* rtl/core/quaternion_to_euler_rpy.sv */
// Registered path: products, sums, pitch square, root, CORDIC and output register.
// Throughput: one quaternion per cycle while in_stall is low; the products, a 29-step root
// pipeline and three CORDIC pipelines all advance together on a shared enable.
// A two-entry output register and skid stage keeps input open while one result waits.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_rpy
// Converts a Q2.14 unit quaternion to ZYX roll and yaw in Q3.13, pitch in Q2.13 radians.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_rpy_assert.svh"

module quaternion_to_euler_rpy import q2e_pkg::*; #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);

  localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << 56;

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // products
  logic v1;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat_w * quat_x;
      p_yz <= quat_y * quat_z;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_wy <= quat_w * quat_y;
      p_zx <= quat_z * quat_x;
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // sums and pitch saturation
  logic v2;
  terms_t s2;
  logic signed [TERM_W-1:0] t2_raw;
  terms_t s2_next;

  always_comb begin
    s2_next.t0 = (TERM_W'(p_wx) + TERM_W'(p_yz)) <<< 1;
    s2_next.t1 = ONE_Q28 - ((TERM_W'(p_xx) + TERM_W'(p_yy)) <<< 1);
    s2_next.t3 = (TERM_W'(p_wz) + TERM_W'(p_xy)) <<< 1;
    s2_next.t4 = ONE_Q28 - ((TERM_W'(p_yy) + TERM_W'(p_zz)) <<< 1);
    t2_raw     = (TERM_W'(p_wy) - TERM_W'(p_zx)) <<< 1;
    if (t2_raw > ONE_Q28)       s2_next.t2 = PITCH_W'(ONE_Q28);
    else if (t2_raw < -ONE_Q28) s2_next.t2 = PITCH_W'(-ONE_Q28);
    else                        s2_next.t2 = PITCH_W'(t2_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) s2 <= s2_next;
  end

  // pitch term squared
  logic v3;
  terms_t s3;
  logic [56:0] t2sq;
  logic signed [2*PITCH_W-1:0] t2sq_full;

  assign t2sq_full = s2.t2 * s2.t2;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3   <= s2;
      t2sq <= t2sq_full[56:0];
    end
  end

  // root pipeline, one result bit per stage
  logic            sq_valid [SQRT_STEPS+1];
  logic [SQ_W-1:0] sq_rem   [SQRT_STEPS+1];
  logic [SQ_W-1:0] sq_res   [SQRT_STEPS+1];
  terms_t          sq_pass  [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) sq_valid[0] <= 1'b0;
    else if (en) sq_valid[0] <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= SQ_ONE - SQ_W'(t2sq);
      sq_res[0]  <= '0;
      sq_pass[0] <= s3;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQ_W-1:0] trial;
    logic            take;

    assign trial = sq_res[k] + BIT;
    assign take  = sq_rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_valid[k+1] <= 1'b0;
      else if (en) sq_valid[k+1] <= sq_valid[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k+1]  <= take ? (sq_rem[k] - trial) : sq_rem[k];
        sq_res[k+1]  <= take ? ((sq_res[k] >> 1) + BIT) : (sq_res[k] >> 1);
        sq_pass[k+1] <= sq_pass[k];
      end
    end
  end

  // angle pipelines
  logic cd_valid [CORDIC_STAGES+1];
  logic [ROOT_W-1:0] root;
  terms_t tp;
  logic signed [15:0] roll_c, yaw_c;
  logic signed [14:0] pitch_c;

  assign root = sq_res[SQRT_STEPS][ROOT_W-1:0];
  assign tp   = sq_pass[SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) cd_valid[0] <= 1'b0;
    else if (en) cd_valid[0] <= sq_valid[SQRT_STEPS];
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_vline
    always_ff @(posedge clk) begin
      if (rst) cd_valid[j+1] <= 1'b0;
      else if (en) cd_valid[j+1] <= cd_valid[j];
    end
  end

  q2e_cordic #(
    .STAGES(CORDIC_STAGES), .FRAC_BITS(ANGLE_FRAC_BITS), .OUT_W(16)
  ) u_roll (
    .clk(clk), .en(en),
    .y_in(VEC_W'(tp.t0)), .x_in(VEC_W'(tp.t1)),
    .angle(roll_c)
  );

  q2e_cordic #(
    .STAGES(CORDIC_STAGES), .FRAC_BITS(ANGLE_FRAC_BITS), .OUT_W(15)
  ) u_pitch (
    .clk(clk), .en(en),
    .y_in(VEC_W'(tp.t2)), .x_in(VEC_W'({1'b0, root})),
    .angle(pitch_c)
  );

  q2e_cordic #(
    .STAGES(CORDIC_STAGES), .FRAC_BITS(ANGLE_FRAC_BITS), .OUT_W(16)
  ) u_yaw (
    .clk(clk), .en(en),
    .y_in(VEC_W'(tp.t3)), .x_in(VEC_W'(tp.t4)),
    .angle(yaw_c)
  );

  // output register and skid stage
  logic               rv;
  logic signed [15:0] skid_roll, skid_yaw;
  logic signed [14:0] skid_pitch;

  assign rv = cd_valid[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= rv;
    end else if (rv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        roll_angle  <= skid_roll;
        pitch_angle <= skid_pitch;
        yaw_angle   <= skid_yaw;
      end
    end else if (!out_valid || !out_stall) begin
      roll_angle  <= roll_c;
      pitch_angle <= pitch_c;
      yaw_angle   <= yaw_c;
    end else begin
      // park the transaction leaving the pipe
      skid_roll  <= roll_c;
      skid_pitch <= pitch_c;
      skid_yaw   <= yaw_c;
    end
  end

  `Q2E_ASSERT_IMPLY(a_skid_has_out, clk, rst, skid_valid, out_valid)
  `Q2E_ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && !out_stall, !skid_valid && out_valid)
  `Q2E_ASSERT_NEXT(a_skid_fill, clk, rst, !skid_valid && out_valid && out_stall && rv, skid_valid)

endmodule

/* verif/tb_quaternion_to_euler_rpy.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion to roll/pitch/yaw converter regression
// Drives unit, near-gimbal-lock and raw quaternions through the converter
// under several idle and stall mixes and compares each angle against a
// bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_rpy import q2e_pkg::*;;

  localparam int STAGES    = 16;
  localparam int FRAC      = 13;
  localparam int LATENCY   = 35 + STAGES;
  localparam int PER_PHASE = 385;
  localparam int HOLD_CYC  = 400;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;

  quat_t  quat_pending[$];
  euler_t angles_due[$];
  int     send_idle_pct;
  int     stall_pct;
  bit     hold_start;
  bit     hold_off;
  bit     in_taken;
  bit     failed;

  quaternion_to_euler_rpy #(
    .CORDIC_STAGES   (STAGES),
    .ANGLE_FRAC_BITS (FRAC)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .quat_w      (quat_w),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint za;
    longint xs;
    longint ys;
    za = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      za = (yv >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STAGES && i < CORDIC_MAX; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        za = za + longint'(atan_q30(5'(i)));
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        za = za - longint'(atan_q30(5'(i)));
      end
    end
    return za;
  endfunction

  // round half up to the output grid, then clamp to the field
  function automatic longint angle_to_grid(longint za, int width);
    longint v;
    longint hi;
    v  = (za + (longint'(1) << (ACC_FRAC - FRAC - 1))) >>> (ACC_FRAC - FRAC);
    hi = (longint'(1) << (width - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v;
  endfunction

  function automatic euler_t predict_euler(quat_t q);
    longint w, x, y, z, one, t0, t1, t2, t3, t4, c;
    euler_t e;
    w   = q.w; x = q.x; y = q.y; z = q.z;
    one = longint'(1) << 28;
    t0  = 2 * (w * x + y * z);
    t1  = one - 2 * (x * x + y * y);
    t2  = 2 * (w * y - z * x);
    if (t2 > one) t2 = one;
    if (t2 < -one) t2 = -one;
    t3  = 2 * (w * z + x * y);
    t4  = one - 2 * (y * y + z * z);
    c   = longint'(floor_root((64'd1 << 56) - longint'(t2 * t2)));
    e.roll  = 16'(angle_to_grid(vector_angle(t0, t1), 16));
    e.pitch = 15'(angle_to_grid(vector_angle(t2, c), 15));
    e.yaw   = 16'(angle_to_grid(vector_angle(t3, t4), 16));
    return e;
  endfunction

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    return q;
  endfunction

  function automatic int rnd_s16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic quat_t random_quat();
    int  kind;
    real c[4];
    real n;
    int  v[4];
    kind = $urandom_range(0, 99);
    if (kind < 10)
      return make_quat(rnd_s16(), rnd_s16(), rnd_s16(), rnd_s16());
    for (int i = 0; i < 4; i++) c[i] = real'(rnd_s16());
    // near gimbal lock: y ~ +-w and z ~ +-x, signs drawn independently
    if (kind < 25) begin
      c[2] = (($urandom_range(0, 1) != 0) ? c[0] : -c[0]) + real'(rnd_s16()) / 256.0;
      c[3] = (($urandom_range(0, 1) != 0) ? c[1] : -c[1]) + real'(rnd_s16()) / 256.0;
    end
    n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
    if (n == 0.0) return make_quat(16384, 0, 0, 0);
    for (int i = 0; i < 4; i++) begin
      v[i] = $rtoi(c[i] / n * 16384.0 + ((c[i] >= 0.0) ? 0.5 : -0.5));
      if (v[i] > 16384) v[i] = 16384;
      if (v[i] < -16384) v[i] = -16384;
    end
    return make_quat(v[0], v[1], v[2], v[3]);
  endfunction

  // accept and check on the rising edge
  always @(posedge clk) begin
    euler_t want;
    euler_t got;
    in_taken = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      angles_due.push_back(predict_euler(make_quat(quat_w, quat_x, quat_y, quat_z)));
      void'(quat_pending.pop_front());
      in_taken = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      got.roll = roll_angle; got.pitch = pitch_angle; got.yaw = yaw_angle;
      if (angles_due.size() == 0) begin
        $display("%0t: unexpected transaction roll=%0d pitch=%0d yaw=%0d",
                 $time, got.roll, got.pitch, got.yaw);
        failed = 1'b1;
      end else begin
        want = angles_due.pop_front();
        if (got.roll !== want.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
          failed = 1'b1;
        end
        if (got.pitch !== want.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
          failed = 1'b1;
        end
        if (got.yaw !== want.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
          failed = 1'b1;
        end
      end
    end
  end

  // driver: hold a stalled transaction, otherwise advance or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      quat_w   <= '0;
      quat_x   <= '0;
      quat_y   <= '0;
      quat_z   <= '0;
    end else if (!in_valid || in_taken) begin
      if (quat_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        quat_w   <= quat_pending[0].w;
        quat_x   <= quat_pending[0].x;
        quat_y   <= quat_pending[0].y;
        quat_z   <= quat_pending[0].z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  // long receiver hold-off so the pipeline fills and backs up
  initial begin
    hold_off = 1'b0;
    wait (hold_start);
    hold_off = 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("quaternion_to_euler_rpy regression: fail");
    $finish;
  end

  initial begin
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_start    = 1'b0;
    rst           = 1'b1;
    repeat (9) @(posedge clk);
    rst = 1'b0;

    // identity, axis rotations, gimbal lock, saturated pitch, zero, raw extremes
    quat_pending.push_back(make_quat(16384, 0, 0, 0));
    quat_pending.push_back(make_quat(-16384, 0, 0, 0));
    quat_pending.push_back(make_quat(0, 16384, 0, 0));
    quat_pending.push_back(make_quat(0, 0, 16384, 0));
    quat_pending.push_back(make_quat(0, 0, 0, 16384));
    quat_pending.push_back(make_quat(0, -16384, 0, 0));
    quat_pending.push_back(make_quat(11585, 11585, 0, 0));
    quat_pending.push_back(make_quat(11585, 0, 0, -11585));
    quat_pending.push_back(make_quat(11585, 0, 11585, 0));
    quat_pending.push_back(make_quat(11585, 0, -11585, 0));
    quat_pending.push_back(make_quat(8192, 8192, 8192, 8192));
    quat_pending.push_back(make_quat(8192, -8192, 8192, -8192));
    quat_pending.push_back(make_quat(16384, 0, 16384, 0));
    quat_pending.push_back(make_quat(16384, 0, -16384, 0));
    quat_pending.push_back(make_quat(0, 0, 0, 0));
    quat_pending.push_back(make_quat(32767, 32767, 32767, 32767));
    quat_pending.push_back(make_quat(-32768, -32768, -32768, -32768));
    quat_pending.push_back(make_quat(32767, -32768, 32767, -32768));
    quat_pending.push_back(make_quat(-32768, 32767, -32768, 32767));
    quat_pending.push_back(make_quat(0, 1, 0, 0));
    quat_pending.push_back(make_quat(-1, 0, 0, -1));
    quat_pending.push_back(make_quat(21845, 0, 21845, 0));
    wait (quat_pending.size() == 0 && angles_due.size() == 0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  hold_start = 1'b1; end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      for (int i = 0; i < PER_PHASE; i++) quat_pending.push_back(random_quat());
      wait (quat_pending.size() == 0 && angles_due.size() == 0);
    end

    stall_pct = 0;
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed)
      $display("quaternion_to_euler_rpy regression: pass");
    else
      $display("quaternion_to_euler_rpy regression: fail");
    $finish;
  end

endmodule
